[rtl/layered_led_pattern_player_core_macros.svh]
// Assertion macros for the layered LED pattern player.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef LAYERED_LED_PATTERN_PLAYER_CORE_MACROS_SVH
`define LAYERED_LED_PATTERN_PLAYER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LLPP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define LLPP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define LLPP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define LLPP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[rtl/llpp_pkg.sv]
// Shared types and constants of the layered LED pattern player.
// No dependencies.
`default_nettype none
package llpp_pkg;
  localparam int LAYERS    = 4;
  localparam int PATTERNS  = 16;
  localparam int INTERVALS = 16;
  localparam int LAY_W = 2;
  localparam int PAT_W = 4;
  localparam int IVL_W = 4;
  localparam int SLOT_W = PAT_W + IVL_W;
  localparam int SLOTS = PATTERNS * INTERVALS;
  localparam int PWM_PERIOD_TOP = 1000 - 1;
  localparam logic [9:0] DEFAULT_LEVEL = 10'((PWM_PERIOD_TOP + 1) / 2);
  localparam logic [9:0] FULL_LEVEL = 10'd1000;
  localparam logic [4:0] MAX_COUNT = 5'(INTERVALS);

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_PAT    = 3'd2,
    CMD_OFF    = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_WR_IVL = 3'd5,
    CMD_WR_CNT = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    RPL_NONE  = 3'd0,
    RPL_START = 3'd1,
    RPL_STOP  = 3'd2,
    RPL_PAT   = 3'd3,
    RPL_OFF   = 3'd4
  } reply_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_REPEAT  = 2'd2,
    MODE_ONCE    = 2'd3
  } mode_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [15:0]       seq;
    logic [LAY_W-1:0]  layer;
    logic [PAT_W-1:0]  pattern;
    logic              rep;
    logic [IVL_W-1:0]  interval;
    logic [15:0]       dur;
    logic [9:0]        level;
    logic [4:0]        count;
  } item_t;

  typedef struct packed {
    reply_t       reply;
    logic         ok;
    logic [15:0]  seq;
    logic         pwm_on;
    logic [9:0]   level;
    logic [1:0]   layer;
    mode_t        mode;
  } result_t;
endpackage
`default_nettype wire

[rtl/layered_led_pattern_player_core.sv]
// Top level of the layered LED pattern player: front decode, queue, back end.
// Depends on llpp_pkg, llpp_front, llpp_queue, llpp_back.
//
// Channel  Dir  Ports                      Word
// in_      in   in_tvalid/tready/tdata     one command word (64 bits)
// out_     out  out_tvalid/tready/tdata    one result word per command (40 bits)
//
// Each command executes in the back end's S_EXEC state; a command that enters a new
// interval then passes through S_LOAD, for the registered read of the interval store.
// A two-entry queue lets the input keep accepting while the back end waits.
// The output register holds a result until taken; the back end stalls on it.
// Reset (rst_n low, synchronous) stops the player and empties the queue;
// the interval and count stores are not cleared.
`default_nettype none
module layered_led_pattern_player_core import llpp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] cmd, [18:3] seq, [20:19] layer, [24:21] pattern, [25] repeat_req,
  // [29:26] interval, [45:30] duration_ms, [55:46] level_permil, [60:56] count
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] reply, [3] reply_ok, [19:4] reply_seq, [20] pwm_on,
  // [30:21] pwm_level, [32:31] playing_layer, [34:33] mode
  output logic [39:0]      out_tdata
);
  item_t   dec_item, q_item;
  logic    q_full, q_empty, q_pop;
  result_t res;

  assign in_tready = !q_full;

  llpp_front u_front (
    .word_i (in_tdata),
    .item_o (dec_item)
  );

  llpp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_tvalid && in_tready),
    .data_i  (dec_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_item)
  );

  llpp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty_i   (q_empty),
    .q_data_i    (q_item),
    .pop_o       (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (res)
  );

  // pack result fields, first field lowest
  assign out_tdata = {5'd0, res.mode, res.layer, res.level, res.pwm_on,
                      res.seq, res.ok, res.reply};
endmodule
`default_nettype wire

[rtl/llpp_front.sv]
// Front end: unpacks and classifies one command word.
// Depends on llpp_pkg.
`default_nettype none
module llpp_front import llpp_pkg::*; (
  input  wire logic [63:0] word_i,
  output item_t            item_o
);
  logic [9:0] lvl;
  always_comb begin
    item_o.cmd      = cmd_t'(word_i[2:0]);
    item_o.seq      = word_i[18:3];
    item_o.layer    = word_i[20:19];
    item_o.pattern  = word_i[24:21];
    item_o.rep      = word_i[25];
    item_o.interval = word_i[29:26];
    item_o.dur      = word_i[45:30];
    lvl             = word_i[55:46];
    // level saturates at full scale on store write
    item_o.level    = (lvl > FULL_LEVEL) ? FULL_LEVEL : lvl;
    item_o.count    = word_i[60:56];
  end
endmodule
`default_nettype wire

[rtl/llpp_queue.sv]
// Two-entry queue between front and back.
// Depends on llpp_pkg.
`default_nettype none
module llpp_queue import llpp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      data_o
);
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign data_o  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wp_r] <= data_i;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= ~wp_r;
      if (pop_i)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

[rtl/llpp_back.sv]
// Back end: layer state, pattern stores, interval timing and result register.
// Depends on llpp_pkg and the assertion macros header.
`default_nettype none
`include "layered_led_pattern_player_core_macros.svh"
module llpp_back import llpp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty_i,
  input  wire item_t q_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output result_t    out_data_o
);
  typedef enum logic {S_EXEC, S_LOAD} state_t;

  state_t               state_r;
  mode_t                mode_r, mode_nxt;
  logic [LAYERS-1:0]    valid_r, valid_nxt, rep_r, rep_nxt;
  logic [PAT_W-1:0]     pat_r [LAYERS];
  logic [PAT_W-1:0]     pat_nxt [LAYERS];
  logic [LAY_W-1:0]     cur_r, cur_nxt;
  logic [IVL_W-1:0]     idx_r, idx_nxt;
  logic [15:0]          ticks_r, ticks_nxt;
  logic [9:0]           level_r, level_nxt;
  logic [15:0]          dur_mem [SLOTS];
  logic [9:0]           lvl_mem [SLOTS];
  logic [4:0]           cnt_mem [PATTERNS];
  logic [15:0]          rd_dur_r;
  logic [9:0]           rd_lvl_r;
  logic [SLOT_W-1:0]    rd_slot;
  reply_t               rpl, rpl_r;
  logic                 ok, ok_r;
  logic [15:0]          seq_r;
  logic                 load;
  logic                 out_free;
  logic                 out_set;
  logic [4:0]           cnt_eff;
  logic                 found;
  item_t                it;
  result_t              out_r;
  logic                 out_valid_r;

  assign it       = q_data_i;
  assign out_free = !out_valid_r || out_ready_i;
  assign pop_o    = (state_r == S_EXEC) && !q_empty_i && out_free;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;
  // a new result word lands in the output register this cycle
  assign out_set  = (pop_o && !load) || (state_r == S_LOAD && out_free);

  always_comb begin
    mode_nxt  = mode_r;
    valid_nxt = valid_r;
    rep_nxt   = rep_r;
    pat_nxt   = pat_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    ticks_nxt = ticks_r;
    level_nxt = level_r;
    rpl       = RPL_NONE;
    ok        = 1'b0;
    load      = 1'b0;
    found     = 1'b0;
    cnt_eff   = cnt_mem[pat_r[cur_r]];
    if (cnt_eff == 5'd0) cnt_eff = 5'd1;
    if (cnt_eff > MAX_COUNT) cnt_eff = MAX_COUNT;
    unique case (it.cmd)
      CMD_START: begin
        rpl = RPL_START;
        if (mode_r == MODE_STOPPED) begin
          ok        = 1'b1;
          level_nxt = DEFAULT_LEVEL;
          cur_nxt   = '0;
          idx_nxt   = '0;
          ticks_nxt = '0;
          valid_nxt = '0;
          rep_nxt   = '0;
          for (int i = 0; i < LAYERS; i++) pat_nxt[i] = '0;
          mode_nxt  = MODE_IDLE;
        end
      end
      CMD_STOP: begin
        rpl       = RPL_STOP;
        ok        = 1'b1;
        ticks_nxt = '0;
        mode_nxt  = MODE_STOPPED;
      end
      CMD_PAT: begin
        if (mode_r != MODE_STOPPED) begin
          rpl = RPL_PAT;
          ok  = 1'b1;
          valid_nxt[it.layer] = 1'b1;
          rep_nxt[it.layer]   = it.rep;
          pat_nxt[it.layer]   = it.pattern;
          if (mode_r == MODE_IDLE) begin
            cur_nxt = it.layer;
            load    = 1'b1;
          end else if (it.layer >= cur_r) begin
            if (mode_r == MODE_ONCE && it.layer > cur_r) valid_nxt[cur_r] = 1'b0;
            cur_nxt = it.layer;
            load    = 1'b1;
          end
        end
      end
      CMD_OFF: begin
        if (mode_r != MODE_STOPPED) begin
          rpl = RPL_OFF;
          ok  = 1'b1;
          if (mode_r == MODE_REPEAT || mode_r == MODE_ONCE) begin
            valid_nxt[it.layer] = 1'b0;
            if (it.layer == cur_r) found = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (mode_r == MODE_REPEAT || mode_r == MODE_ONCE) begin
          if (ticks_r > 16'd1) ticks_nxt = ticks_r - 16'd1;
          else if (5'(idx_r) + 5'd1 < cnt_eff) begin
            idx_nxt = idx_r + 4'd1;
            load    = 1'b1;
          end else if (mode_r == MODE_REPEAT) begin
            idx_nxt = '0;
            load    = 1'b1;
          end else begin
            valid_nxt[cur_r] = 1'b0;
            found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // found flags a pattern end: fall back to the highest valid layer
    if (found) begin
      found     = 1'b0;
      cur_nxt   = '0;
      ticks_nxt = '0;
      mode_nxt  = MODE_IDLE;
      for (int l = 0; l < LAYERS; l++) begin
        if (valid_nxt[l]) begin
          cur_nxt = LAY_W'(l);
          found   = 1'b1;
        end
      end
      if (found) load = 1'b1;
    end
    if (load) begin
      if (it.cmd == CMD_PAT || found) idx_nxt = '0;
      mode_nxt = rep_nxt[cur_nxt] ? MODE_REPEAT : MODE_ONCE;
    end
    rd_slot = {pat_nxt[cur_nxt], idx_nxt};
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      if (it.cmd == CMD_WR_IVL) begin
        dur_mem[{it.pattern, it.interval}] <= it.dur;
        lvl_mem[{it.pattern, it.interval}] <= it.level;
      end
      if (it.cmd == CMD_WR_CNT) cnt_mem[it.pattern] <= it.count;
      rd_dur_r <= dur_mem[rd_slot];
      rd_lvl_r <= lvl_mem[rd_slot];
      rpl_r    <= rpl;
      ok_r     <= ok;
      seq_r    <= it.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      mode_r      <= MODE_STOPPED;
      valid_r     <= '0;
      rep_r       <= '0;
      for (int i = 0; i < LAYERS; i++) pat_r[i] <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      ticks_r     <= '0;
      level_r     <= DEFAULT_LEVEL;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (out_set) out_valid_r <= 1'b1;
      else if (out_ready_i) out_valid_r <= 1'b0;
      unique case (state_r)
        S_EXEC: begin
          if (pop_o) begin
            mode_r  <= mode_nxt;
            valid_r <= valid_nxt;
            rep_r   <= rep_nxt;
            pat_r   <= pat_nxt;
            cur_r   <= cur_nxt;
            idx_r   <= idx_nxt;
            ticks_r <= ticks_nxt;
            level_r <= level_nxt;
            if (load) state_r <= S_LOAD;
            else begin
              out_r.reply  <= rpl;
              out_r.ok     <= ok;
              out_r.seq    <= (rpl == RPL_NONE) ? 16'd0 : it.seq;
              out_r.pwm_on <= (mode_nxt == MODE_REPEAT || mode_nxt == MODE_ONCE);
              out_r.level  <= level_nxt;
              out_r.layer  <= cur_nxt;
              out_r.mode   <= mode_nxt;
            end
          end
        end
        S_LOAD: begin
          if (out_free) begin
            ticks_r      <= (rd_dur_r == 16'd0) ? 16'd1 : rd_dur_r;
            level_r      <= rd_lvl_r;
            state_r      <= S_EXEC;
            out_r.reply  <= rpl_r;
            out_r.ok     <= ok_r;
            out_r.seq    <= (rpl_r == RPL_NONE) ? 16'd0 : seq_r;
            out_r.pwm_on <= (mode_r == MODE_REPEAT || mode_r == MODE_ONCE);
            out_r.level  <= rd_lvl_r;
            out_r.layer  <= cur_r;
            out_r.mode   <= mode_r;
          end
        end
        default: state_r <= S_EXEC;
      endcase
    end
  end

  `LLPP_ASSERT_IMP(a_no_pop_in_load, clk, rst_n, state_r == S_LOAD, !pop_o, "pop during load")
  `LLPP_ASSERT_IMP(a_ticks_live, clk, rst_n,
    state_r == S_EXEC && (mode_r == MODE_REPEAT || mode_r == MODE_ONCE),
    ticks_r != 16'd0, "playing with no ticks left")
  `LLPP_ASSERT_NXT(a_load_done, clk, rst_n, state_r == S_LOAD && out_free,
    state_r == S_EXEC && out_valid_r, "load did not complete")
endmodule
`default_nettype wire

[tb/layered_led_pattern_player_core_tb.sv]
// Testbench for the layered LED pattern player core: directed table, then random commands.
// Depends on llpp_pkg and layered_led_pattern_player_core; a built-in predictor checks each word.
`timescale 1ns / 100ps
`default_nettype none
module layered_led_pattern_player_core_tb;
  import llpp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  layered_led_pattern_player_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Command fields as the player sees them.
  typedef struct {
    cmd_t        cmd;
    logic [15:0] seq;
    logic [1:0]  layer;
    logic [3:0]  pattern;
    logic        rep;
    logic [3:0]  interval;
    logic [15:0] dur;
    logic [9:0]  level;
    logic [4:0]  count;
  } command_s;

  typedef struct {
    reply_t      reply;
    logic        ok;
    logic [15:0] seq;
    logic        pwm_on;
    logic [9:0]  level;
    logic [1:0]  layer;
    mode_t       mode;
  } status_s;

  // Predictor state.
  mode_t       pm_mode;
  logic        pm_valid [LAYERS];
  logic        pm_rep [LAYERS];
  logic [3:0]  pm_pat [LAYERS];
  logic [1:0]  pm_layer;
  logic [3:0]  pm_ivl;
  logic [16:0] pm_ticks;
  logic [9:0]  pm_level;
  logic [15:0] dur_store [SLOTS];
  logic [9:0]  lvl_store [SLOTS];
  logic [4:0]  cnt_store [PATTERNS];
  // Written-ness, so random requests never read an unwritten entry.
  bit          ivl_written [SLOTS];
  bit          cnt_written [PATTERNS];

  status_s pending_status [$];
  int      mismatches;
  int      words_sent;
  int      words_checked;
  int      replies_seen;
  longint  cycle_count;
  bit      hold_off;

  function automatic logic [7:0] slot_of(logic [3:0] p, logic [3:0] i);
    return {p, i};
  endfunction

  function automatic void enter_interval();
    logic [7:0] s;
    s = slot_of(pm_pat[pm_layer], pm_ivl);
    pm_ticks = (dur_store[s] == 16'd0) ? 17'd1 : {1'b0, dur_store[s]};
    pm_level = lvl_store[s];
    pm_mode  = pm_rep[pm_layer] ? MODE_REPEAT : MODE_ONCE;
  endfunction

  function automatic void pattern_finished();
    int l;
    for (l = LAYERS - 1; l >= 0; l--) begin
      if (pm_valid[l]) begin
        pm_layer = l[1:0];
        pm_ivl = '0;
        enter_interval();
        return;
      end
    end
    pm_layer = '0;
    pm_ticks = '0;
    pm_mode  = MODE_IDLE;
  endfunction

  function automatic void interval_finished();
    int c;
    c = cnt_store[pm_pat[pm_layer]];
    if (c == 0) c = 1;
    if (c > INTERVALS) c = INTERVALS;
    if (int'(pm_ivl) + 1 < c) begin
      pm_ivl++;
      enter_interval();
    end else if (pm_mode == MODE_REPEAT) begin
      pm_ivl = '0;
      enter_interval();
    end else begin
      pm_valid[pm_layer] = 1'b0;
      pattern_finished();
    end
  endfunction

  function automatic void player_reset();
    pm_mode = MODE_STOPPED;
    for (int l = 0; l < LAYERS; l++) begin
      pm_valid[l] = 1'b0; pm_rep[l] = 1'b0; pm_pat[l] = '0;
    end
    pm_layer = '0; pm_ivl = '0; pm_ticks = '0; pm_level = DEFAULT_LEVEL;
  endfunction

  // Works out the status word that one command produces.
  function automatic status_s predict_status(command_s c);
    status_s r;
    bit started, playing;
    logic [7:0] s;
    started = pm_mode != MODE_STOPPED;
    playing = pm_mode == MODE_REPEAT || pm_mode == MODE_ONCE;
    r.reply = RPL_NONE;
    r.ok = 0;
    case (c.cmd)
      CMD_START: begin
        r.reply = RPL_START;
        if (!started) begin
          r.ok = 1;
          player_reset();
          pm_mode = MODE_IDLE;
        end
      end
      CMD_STOP: begin
        r.reply = RPL_STOP; r.ok = 1; pm_ticks = '0; pm_mode = MODE_STOPPED;
      end
      CMD_PAT: if (started) begin
        r.reply = RPL_PAT; r.ok = 1;
        pm_valid[c.layer] = 1; pm_rep[c.layer] = c.rep; pm_pat[c.layer] = c.pattern;
        if (!playing) begin
          pm_layer = c.layer; pm_ivl = '0; enter_interval();
        end else if (c.layer >= pm_layer) begin
          if (pm_mode == MODE_ONCE && c.layer > pm_layer) pm_valid[pm_layer] = 0;
          pm_layer = c.layer; pm_ivl = '0; enter_interval();
        end
      end
      CMD_OFF: if (started) begin
        r.reply = RPL_OFF; r.ok = 1;
        if (playing) begin
          pm_valid[c.layer] = 0;
          if (c.layer == pm_layer) pattern_finished();
        end
      end
      CMD_TICK: if (playing) begin
        if (pm_ticks > 1) pm_ticks--;
        else interval_finished();
      end
      CMD_WR_IVL: begin
        s = slot_of(c.pattern, c.interval);
        dur_store[s] = c.dur;
        lvl_store[s] = (c.level > FULL_LEVEL) ? FULL_LEVEL : c.level;
        ivl_written[s] = 1;
      end
      CMD_WR_CNT: begin
        cnt_store[c.pattern] = c.count;
        cnt_written[c.pattern] = 1;
      end
      default: ;
    endcase
    r.seq = (r.reply != RPL_NONE) ? c.seq : 16'd0;
    r.pwm_on = pm_mode == MODE_REPEAT || pm_mode == MODE_ONCE;
    r.level = pm_level;
    r.layer = pm_layer;
    r.mode = pm_mode;
    return r;
  endfunction

  function automatic logic [63:0] pack_command(command_s c);
    return {3'd0, c.count, c.level, c.dur, c.interval, c.rep, c.pattern, c.layer,
            c.seq, c.cmd};
  endfunction

  // A pattern is safe to request once every slot it could read is written.
  function automatic bit pattern_ready(logic [3:0] p);
    if (!cnt_written[p]) return 0;
    for (int i = 0; i < INTERVALS; i++)
      if (!ivl_written[slot_of(p, i[3:0])]) return 0;
    return 1;
  endfunction

  // Sender: offers one word, waits for the handshake, with random gaps.
  // tvalid stays high between words unless a gap drops it.
  task automatic send_word(command_s c, bit gaps);
    int g;
    g = 0;
    if (gaps) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
    end
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tdata  <= pack_command(c);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(predict_status(c));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic command_s blank_command(cmd_t k);
    command_s c;
    c = '{cmd: k, seq: 16'($urandom), layer: '0, pattern: '0, rep: 1'b0, interval: '0,
          dur: '0, level: '0, count: '0};
    return c;
  endfunction

  // Random command, mostly well-formed with random content.
  function automatic command_s random_command();
    command_s c;
    int pick;
    c.cmd = CMD_TICK; c.seq = 16'($urandom); c.layer = 2'($urandom);
    c.pattern = 4'($urandom);
    c.rep = 1'($urandom); c.interval = 4'($urandom); c.dur = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 15) == 0) c.dur = 16'($urandom);
    c.level = 10'($urandom); c.count = 5'($urandom_range(0, 16));
    if ($urandom_range(0, 9) == 0) c.count = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) c.cmd = CMD_START;
    else if (pick < 5) c.cmd = CMD_STOP;
    else if (pick < 25) c.cmd = CMD_PAT;
    else if (pick < 33) c.cmd = CMD_OFF;
    else if (pick < 80) c.cmd = CMD_TICK;
    else if (pick < 90) c.cmd = CMD_WR_IVL;
    else if (pick < 96) c.cmd = CMD_WR_CNT;
    else c.cmd = CMD_NOP;
    // steer requests to fully written patterns
    if (c.cmd == CMD_PAT && !pattern_ready(c.pattern)) begin
      c.pattern = 4'($urandom_range(0, 3));
      if (!pattern_ready(c.pattern)) c.cmd = CMD_TICK;
    end
    return c;
  endfunction

  // Directed table: cmd, seq, layer, pattern, rep, interval, dur, level, count,
  // with a typed-in expectation where obvious (chk set).
  typedef struct {
    command_s cmd;
    bit       chk;
    status_s  st;
  } table_row_s;

  table_row_s dir_rows [$];

  task automatic add_row(cmd_t k, logic [15:0] sq, logic [1:0] ly, logic [3:0] pt,
                         logic rp, logic [3:0] iv, logic [15:0] du, logic [9:0] lv,
                         logic [4:0] ct, bit chk, status_s st);
    table_row_s row;
    row.cmd = '{cmd: k, seq: sq, layer: ly, pattern: pt, rep: rp, interval: iv,
                dur: du, level: lv, count: ct};
    row.chk = chk;
    row.st = st;
    dir_rows.push_back(row);
  endtask

  task automatic check_word(logic [39:0] w);
    status_s e;
    if (pending_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", w);
      return;
    end
    e = pending_status.pop_front();
    words_checked++;
    if (e.reply != RPL_NONE) replies_seen++;
    if (w[2:0] !== e.reply || w[3] !== e.ok || w[19:4] !== e.seq ||
        w[20] !== e.pwm_on || w[30:21] !== e.level || w[32:31] !== e.layer ||
        w[34:33] !== e.mode || w[39:35] !== 5'd0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp reply %0d ok %0d seq %h on %0d lvl %0d lay %0d mode %0d, got %h",
                 e.reply, e.ok, e.seq, e.pwm_on, e.level, e.layer, e.mode, w);
    end
  endtask

  // Output side: random stalls, one long hold-off, compare against the queue.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      stall = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) check_word(out_tdata);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("[layered_led_pattern_player_core] ERROR");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    command_s c;
    status_s  z;
    int n;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    mismatches = 0; words_sent = 0; words_checked = 0; replies_seen = 0;
    hold_off = 0;
    player_reset();
    for (int i = 0; i < SLOTS; i++) ivl_written[i] = 0;
    for (int i = 0; i < PATTERNS; i++) cnt_written[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    z = '{reply: RPL_NONE, ok: 0, seq: 0, pwm_on: 0, level: DEFAULT_LEVEL, layer: 0,
          mode: MODE_STOPPED};
    // stopped: stop confirms, requests and ticks silent
    add_row(CMD_STOP, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 1,
            '{RPL_STOP, 1'b1, 16'hFFFF, 1'b0, DEFAULT_LEVEL, 2'd0, MODE_STOPPED});
    add_row(CMD_PAT, 16'h1234, 3, 15, 1, 0, 0, 0, 0, 1, z);
    add_row(CMD_OFF, 16'h0001, 3, 0, 0, 0, 0, 0, 0, 1, z);
    add_row(CMD_TICK, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 1, z);
    add_row(CMD_NOP, 16'hAAAA, 3, 15, 1, 15, 16'hFFFF, 10'h3FF, 31, 1, z);
    // fill patterns 0..3 fully; extremes of duration and level
    for (int p = 0; p < 4; p++)
      for (int i = 0; i < INTERVALS; i++)
        add_row(CMD_WR_IVL, 0, 0, p[3:0], 0, i[3:0],
                (p == 3 && i == 0) ? 16'hFFFF : 16'(i % 3), 10'(p * 250 + i * 20 + 1),
                0, 0, z);
    add_row(CMD_WR_IVL, 16'h5555, 3, 2, 1, 15, 16'd0, 10'h3FF, 0, 0, z);
    add_row(CMD_WR_CNT, 0, 0, 0, 0, 0, 0, 0, 5'd0, 0, z);
    add_row(CMD_WR_CNT, 0, 0, 1, 0, 0, 0, 0, 5'd3, 0, z);
    add_row(CMD_WR_CNT, 0, 0, 2, 0, 0, 0, 0, 5'd31, 0, z);
    add_row(CMD_WR_CNT, 0, 0, 3, 0, 0, 0, 0, 5'd16, 0, z);
    add_row(CMD_START, 16'h00AA, 0, 0, 0, 0, 0, 0, 0, 1,
            '{RPL_START, 1'b1, 16'h00AA, 1'b0, DEFAULT_LEVEL, 2'd0, MODE_IDLE});
    add_row(CMD_START, 16'h00AB, 0, 0, 0, 0, 0, 0, 0, 1,
            '{RPL_START, 1'b0, 16'h00AB, 1'b0, DEFAULT_LEVEL, 2'd0, MODE_IDLE});
    add_row(CMD_OFF, 16'h0002, 2, 0, 0, 0, 0, 0, 0, 1,
            '{RPL_OFF, 1'b1, 16'h0002, 1'b0, DEFAULT_LEVEL, 2'd0, MODE_IDLE});
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1,
            '{RPL_NONE, 1'b0, 16'h0, 1'b0, DEFAULT_LEVEL, 2'd0, MODE_IDLE});
    add_row(CMD_PAT, 16'h0003, 0, 1, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_PAT, 16'h0004, 3, 2, 1, 0, 0, 0, 0, 0, z);
    add_row(CMD_PAT, 16'h0005, 1, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_OFF, 16'h0006, 3, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
    add_row(CMD_STOP, 16'h0007, 0, 0, 0, 0, 0, 0, 0, 0, z);

    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].cmd, 1'b0);
      if (dir_rows[k].chk) begin
        // overwrite prediction with the typed-in expectation; they must agree
        if (pending_status[$] != dir_rows[k].st) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with predictor", k);
        end
        pending_status[$] = dir_rows[k].st;
      end
    end
    wait_drained();

    // random part; long receiver hold-off midway, one full drain pause
    c = blank_command(CMD_START);
    send_word(c, 1'b1);
    for (n = 0; n < 750; n++) begin
      if (n == 200) hold_off = 1;
      if (n == 450) wait_drained();
      send_word(random_command(), ($urandom_range(0, 4) != 0) && (n < 300 || n > 400));
    end
    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d command words, checked %0d status words, %0d with a reply",
             words_sent, words_checked, replies_seen);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("[layered_led_pattern_player_core] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[layered_led_pattern_player_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
